@@ sv/ntta_pkg.sv @@
// ----------------------------------------------------------------------------
// ntta_pkg: shared types and constants of the neighbor table
// Field widths, status codes, table entry layout and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ntta_pkg;

  // field widths
  localparam int ID_W    = 48;
  localparam int IP_W    = 32;
  localparam int COST_W  = 16;
  localparam int LEN_W   = 11;
  localparam int TTL_W   = 8;
  localparam int COUNT_W = 5;

  // default table size and register reset
  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [TTL_W-1:0] MAX_TTL_RST = 8'd3;
  localparam logic [LEN_W-1:0] HELLO_LEN   = 11'd2;

  // input tdata layout, lowest field first
  localparam int IN_ID_LSB   = 0;
  localparam int IN_IP_LSB   = IN_ID_LSB + ID_W;
  localparam int IN_COST_LSB = IN_IP_LSB + IP_W;
  localparam int IN_LEN_LSB  = IN_COST_LSB + COST_W;
  localparam int IN_USED_W   = IN_LEN_LSB + LEN_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest field first
  localparam int STATUS_W     = 3;
  localparam int OUT_ID_LSB   = STATUS_W;
  localparam int OUT_COST_LSB = OUT_ID_LSB + ID_W;
  localparam int OUT_CNT_LSB  = OUT_COST_LSB + COST_W;
  localparam int OUT_USED_W   = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 3'd0,
    ST_ADDED     = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_t;

  // one neighbor table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] cost;
    logic [IP_W-1:0]   ip;
    logic [TTL_W-1:0]  ttl;
  } entry_t;

  // one expired neighbor waiting to be reported
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] cost;
  } gone_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;      // input transfer, latch fields and clear pointers
    logic    scan;        // read the next table entry if any is left
    logic    tick_step;   // compact the entry in the compare stage
    logic    wr_refresh;  // write back the matched entry
    logic    wr_append;   // append a new entry at the table end
    logic    tick_commit; // take the survivor count, rewind report pointer
    logic    gone_rd;     // read the next expired entry
    logic    e_inc;       // step the report pointer
    logic    out_load;    // load the output register
    status_t out_status;
    logic    out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_hello;
    logic in_len_bad;
    logic rd_done;
    logic cmp_vld;
    logic match;
    logic full;
    logic gone_left;
    logic out_free;
  } sts_t;

endpackage

@@ sv/ntta_ctrl.sv @@
// ----------------------------------------------------------------------------
// ntta_ctrl: sequencer of the neighbor table
// Walks each hello or tick through its scan and report phases and drives
// the datapath by command; decisions come from the datapath status.
// ----------------------------------------------------------------------------
module ntta_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ntta_pkg::sts_t  sts,
  output ntta_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_H_SCAN,
    S_H_EMIT,
    S_T_SCAN,
    S_T_RD,
    S_T_OUT,
    S_T_DONE
  } state_t;

  state_t              state_r, state_nxt;
  ntta_pkg::status_t   status_r, status_nxt;
  logic                accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    cmd             = '0;
    cmd.out_status  = status_r;
    cmd.accept      = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!sts.in_hello) begin
            state_nxt = S_T_SCAN;
          end else if (sts.in_len_bad) begin
            status_nxt = ntta_pkg::ST_BAD_LEN;
            state_nxt  = S_H_EMIT;
          end else begin
            state_nxt = S_H_SCAN;
          end
        end
      end
      S_H_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.wr_refresh = 1'b1;
          status_nxt     = ntta_pkg::ST_REFRESHED;
          state_nxt      = S_H_EMIT;
        end else if (sts.rd_done && !sts.cmp_vld) begin
          if (sts.full) begin
            status_nxt = ntta_pkg::ST_FULL;
          end else begin
            cmd.wr_append = 1'b1;
            status_nxt    = ntta_pkg::ST_ADDED;
          end
          state_nxt = S_H_EMIT;
        end
      end
      S_H_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_T_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.tick_step = 1'b1;
        if (sts.rd_done && !sts.cmp_vld) begin
          cmd.tick_commit = 1'b1;
          state_nxt       = S_T_RD;
        end
      end
      S_T_RD: begin
        if (sts.gone_left) begin
          cmd.gone_rd = 1'b1;
          state_nxt   = S_T_OUT;
        end else begin
          state_nxt = S_T_DONE;
        end
      end
      S_T_OUT: begin
        cmd.out_status = ntta_pkg::ST_EXPIRED;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.e_inc    = 1'b1;
          state_nxt    = S_T_RD;
        end
      end
      S_T_DONE: begin
        cmd.out_status = ntta_pkg::ST_TICK_DONE;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and held result status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ntta_pkg::ST_REFRESHED;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

@@ sv/ntta_dp.sv @@
// ----------------------------------------------------------------------------
// ntta_dp: datapath of the neighbor table
// Table memory with registered read, compare and compaction stage, store of
// expired entries, entry count, max_ttl register and the output register.
// ----------------------------------------------------------------------------
module ntta_dp #(
  parameter int TABLE_DEPTH = ntta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ntta_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_valid,
  input  logic [ntta_pkg::TTL_W-1:0]         cfg_data,
  input  ntta_pkg::cmd_t                     cmd,
  output ntta_pkg::sts_t                     sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ntta_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // storage
  ntta_pkg::entry_t tbl_mem  [TABLE_DEPTH];
  ntta_pkg::gone_t  gone_mem [TABLE_DEPTH];

  // latched hello fields
  logic [ntta_pkg::ID_W-1:0]    in_id_r;
  logic [ntta_pkg::IP_W-1:0]    in_ip_r;
  logic [ntta_pkg::COST_W-1:0]  in_cost_r;

  logic [ntta_pkg::TTL_W-1:0]   max_ttl_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                rd_ptr_r;
  logic [CW-1:0]                keep_r;
  logic [CW-1:0]                gone_cnt_r;
  logic [CW-1:0]                e_ptr_r;
  logic                         cmp_vld_r;
  logic [IW-1:0]                cmp_idx_r;
  ntta_pkg::entry_t             rd_q;
  ntta_pkg::gone_t              gone_q;

  logic                         rd_en;
  logic                         tick_upd;
  logic [ntta_pkg::TTL_W-1:0]   ttl_dec;
  logic                         expire;
  logic                         tbl_we;
  logic [IW-1:0]                tbl_wa;
  ntta_pkg::entry_t             tbl_wd;

  // output register
  logic                         out_vld_r;
  ntta_pkg::status_t            out_status_r;
  logic [ntta_pkg::ID_W-1:0]    out_id_r;
  logic [ntta_pkg::COST_W-1:0]  out_cost_r;
  logic [ntta_pkg::COUNT_W-1:0] out_cnt_r;
  logic                         out_last_r;
  logic [ntta_pkg::ID_W-1:0]    out_id_nxt;
  logic [ntta_pkg::COST_W-1:0]  out_cost_nxt;

  // status toward the controller
  assign sts.in_hello   = in_tuser;
  assign sts.in_len_bad = in_tdata[ntta_pkg::IN_LEN_LSB +: ntta_pkg::LEN_W] != ntta_pkg::HELLO_LEN;
  assign sts.rd_done    = (rd_ptr_r == count_r);
  assign sts.cmp_vld    = cmp_vld_r;
  assign sts.match      = cmp_vld_r && (rd_q.id == in_id_r);
  assign sts.full       = (count_r == CW'(TABLE_DEPTH));
  assign sts.gone_left  = (e_ptr_r != gone_cnt_r);
  assign sts.out_free   = !out_vld_r || out_tready;

  // latch the input fields on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_id_r   <= in_tdata[ntta_pkg::IN_ID_LSB +: ntta_pkg::ID_W];
      in_ip_r   <= in_tdata[ntta_pkg::IN_IP_LSB +: ntta_pkg::IP_W];
      in_cost_r <= in_tdata[ntta_pkg::IN_COST_LSB +: ntta_pkg::COST_W];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ttl_r <= ntta_pkg::MAX_TTL_RST;
    end else if (cfg_valid) begin
      max_ttl_r <= cfg_data;
    end
  end

  // scan read, one entry per cycle
  assign rd_en = cmd.scan && (rd_ptr_r != count_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= tbl_mem[rd_ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      cmp_vld_r <= 1'b0;
      cmp_idx_r <= '0;
    end else begin
      if (cmd.accept) begin
        rd_ptr_r <= '0;
      end else if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + CW'(1);
      end
      cmp_vld_r <= rd_en && !cmd.accept;
      cmp_idx_r <= rd_ptr_r[IW-1:0];
    end
  end

  // aging of the entry in the compare stage
  assign tick_upd = cmd.tick_step && cmp_vld_r;
  assign ttl_dec  = rd_q.ttl - 8'd1;
  assign expire   = (ttl_dec == '0);

  // table write port: refresh, append or compaction
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = cmp_idx_r;
    tbl_wd = rd_q;
    priority if (cmd.wr_refresh) begin
      tbl_we      = 1'b1;
      tbl_wd.cost = in_cost_r;
      tbl_wd.ttl  = max_ttl_r;
    end else if (cmd.wr_append) begin
      tbl_we = 1'b1;
      tbl_wa = count_r[IW-1:0];
      tbl_wd = '{id: in_id_r, cost: in_cost_r, ip: in_ip_r, ttl: max_ttl_r};
    end else if (tick_upd && !expire) begin
      tbl_we     = 1'b1;
      tbl_wa     = keep_r[IW-1:0];
      tbl_wd.ttl = ttl_dec;
    end else begin
      tbl_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  // expired entries wait here until the count is final
  always_ff @(posedge clk) begin
    if (tick_upd && expire) begin
      gone_mem[gone_cnt_r[IW-1:0]] <= '{id: rd_q.id, cost: rd_q.cost};
    end
    if (cmd.gone_rd) begin
      gone_q <= gone_mem[e_ptr_r[IW-1:0]];
    end
  end

  // entry count and compaction pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      keep_r     <= '0;
      gone_cnt_r <= '0;
      e_ptr_r    <= '0;
    end else begin
      if (cmd.wr_append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.tick_commit) begin
        count_r <= keep_r;
      end
      if (cmd.accept) begin
        keep_r     <= '0;
        gone_cnt_r <= '0;
      end else if (tick_upd) begin
        if (expire) begin
          gone_cnt_r <= gone_cnt_r + CW'(1);
        end else begin
          keep_r <= keep_r + CW'(1);
        end
      end
      if (cmd.tick_commit) begin
        e_ptr_r <= '0;
      end else if (cmd.e_inc) begin
        e_ptr_r <= e_ptr_r + CW'(1);
      end
    end
  end

  // result fields by status
  always_comb begin
    unique case (cmd.out_status)
      ntta_pkg::ST_REFRESHED, ntta_pkg::ST_ADDED: begin
        out_id_nxt   = in_id_r;
        out_cost_nxt = in_cost_r;
      end
      ntta_pkg::ST_EXPIRED: begin
        out_id_nxt   = gone_q.id;
        out_cost_nxt = gone_q.cost;
      end
      ntta_pkg::ST_TICK_DONE: begin
        out_id_nxt   = '0;
        out_cost_nxt = '0;
      end
      default: begin
        out_id_nxt   = in_id_r;
        out_cost_nxt = '0;
      end
    endcase
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_id_r     <= out_id_nxt;
      out_cost_r   <= out_cost_nxt;
      out_cnt_r    <= ntta_pkg::COUNT_W'(count_r);
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = ntta_pkg::OUT_TDATA_W'({out_cnt_r, out_cost_r, out_id_r, out_status_r});

endmodule

@@ sv/neighbor_table_ttl_aging_top.sv @@
// ----------------------------------------------------------------------------
// neighbor_table_ttl_aging_top: mesh neighbor table with TTL aging
// Insertion-ordered table of neighbors refreshed by hellos and aged by ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per transfer; in_tuser = 1 for a hello, 0 for a tick.
//            A tick ignores in_tdata.
//   out_*  : result items; out_tlast marks the final result of an item.
//            A hello gives one result, a tick one per expired neighbor
//            followed by a tick-done summary.
//   cfg_*  : writes max_ttl, always ready; write only while the block is idle.
// Work per item, for a table holding N entries (the table memory gives one entry
// per cycle through its single read port):
//   hello with bad length : no table scan before the result
//   other hello           : scans up to N entries (stops early on a match)
//   tick with E expired   : scans all N entries, then E results and the summary
// One item is in work at a time; in_tready returns as soon as the last
// result is in the output register, so the next item may enter while it
// waits. A stalled receiver holds the output register and the sequencer.
// Reset clears the table to empty and max_ttl to 3; no clearing pass.
// ----------------------------------------------------------------------------
module neighbor_table_ttl_aging_top #(
  parameter int TABLE_DEPTH = ntta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sender_id[47:0], sender_ip[79:48], link_cost[95:80], payload_len[106:96]
  input  logic [ntta_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func[0]
  input  logic                              in_tuser,
  // configuration channel: max_ttl
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ntta_pkg::TTL_W-1:0]        cfg_data,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[2:0], neighbor_id[50:3], neighbor_cost[66:51], neighbor_count[71:67]
  output logic [ntta_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  ntta_pkg::cmd_t cmd;
  ntta_pkg::sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  ntta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ bench/neighbor_table_ttl_aging_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_table_ttl_aging_top_tb: self-checking bench for the neighbor table
// Sends hello and tick transfers through the input stream. A local copy of
// the table predicts each status, ID, cost, count and last flag. Both stream
// sides idle at random. The max_ttl register is rewritten between phases.
// ----------------------------------------------------------------------------
module neighbor_table_ttl_aging_top_tb;

  localparam int DEPTH      = ntta_pkg::TABLE_DEPTH_DEF;
  localparam int POOL_SIZE  = 24;
  localparam int QUIET_MAX  = 3000;
  localparam int END_CYCLES = 60;

  // one hello or tick as it travels on the input stream
  typedef struct packed {
    logic                            hello;
    logic [ntta_pkg::IN_TDATA_W-1:0] data;
  } neighbor_msg_t;

  // one predicted result transfer
  typedef struct packed {
    ntta_pkg::status_t             status;
    logic [ntta_pkg::ID_W-1:0]     id;
    logic [ntta_pkg::COST_W-1:0]   cost;
    logic [ntta_pkg::COUNT_W-1:0]  count;
    logic                          last;
  } table_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [ntta_pkg::IN_TDATA_W-1:0] in_tdata;
  logic cfg_valid, cfg_ready;
  logic [ntta_pkg::TTL_W-1:0] cfg_data;
  logic out_tvalid, out_tready, out_tlast;
  logic [ntta_pkg::OUT_TDATA_W-1:0] out_tdata;

  neighbor_msg_t             msg_backlog[$];
  table_report_t             table_reports[$];
  logic [ntta_pkg::ID_W-1:0] id_pool[POOL_SIZE];

  // predicted table contents
  ntta_pkg::entry_t           nbr_table[DEPTH];
  int                         nbr_count;
  logic [ntta_pkg::TTL_W-1:0] cur_max_ttl;

  neighbor_msg_t next_msg;
  logic          in_took;
  int            in_gap, in_calm, out_stall, out_calm;
  int            quiet_cycles;
  int            mismatch_count;

  neighbor_table_ttl_aging_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ntta_pkg::ID_W-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ntta_pkg::ID_W-1:0];
  endfunction

  function automatic neighbor_msg_t hello_msg(logic [ntta_pkg::ID_W-1:0] id,
                                              logic [ntta_pkg::IP_W-1:0] ip,
                                              logic [ntta_pkg::COST_W-1:0] cost,
                                              logic [ntta_pkg::LEN_W-1:0] len);
    neighbor_msg_t m;
    m.hello = 1'b1;
    m.data  = '0;
    m.data[ntta_pkg::IN_ID_LSB +: ntta_pkg::ID_W]     = id;
    m.data[ntta_pkg::IN_IP_LSB +: ntta_pkg::IP_W]     = ip;
    m.data[ntta_pkg::IN_COST_LSB +: ntta_pkg::COST_W] = cost;
    m.data[ntta_pkg::IN_LEN_LSB +: ntta_pkg::LEN_W]   = len;
    return m;
  endfunction

  // tick carries random junk in tdata, which must be ignored
  function automatic neighbor_msg_t tick_msg();
    neighbor_msg_t m;
    logic [127:0]  r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    m.hello = 1'b0;
    m.data  = r[ntta_pkg::IN_TDATA_W-1:0];
    return m;
  endfunction

  // append one item to the pending queue
  function automatic void queue_msg(neighbor_msg_t m);
    msg_backlog = {msg_backlog, m};
  endfunction

  // random hello fields sized to the stream layout
  function automatic logic [ntta_pkg::COST_W-1:0] rand_cost();
    return ntta_pkg::COST_W'($urandom_range(65535));
  endfunction

  function automatic logic [ntta_pkg::LEN_W-1:0] rand_len();
    return ntta_pkg::LEN_W'($urandom_range(2047));
  endfunction

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(29) == 0) calm = $urandom_range(60, 20);
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void push_report(ntta_pkg::status_t st, logic [ntta_pkg::ID_W-1:0] id,
                                      logic [ntta_pkg::COST_W-1:0] cost, logic last);
    table_report_t r;
    r.status = st;
    r.id     = id;
    r.cost   = cost;
    r.count  = nbr_count[ntta_pkg::COUNT_W-1:0];
    r.last   = last;
    table_reports = {table_reports, r};
  endfunction

  // apply one accepted item to the local table and queue its results
  function automatic void update_neighbor_table(logic hello,
                                                logic [ntta_pkg::IN_TDATA_W-1:0] d);
    logic [ntta_pkg::ID_W-1:0]   id;
    logic [ntta_pkg::IP_W-1:0]   ip;
    logic [ntta_pkg::COST_W-1:0] cost;
    logic [ntta_pkg::LEN_W-1:0]  len;
    logic [ntta_pkg::TTL_W-1:0]  ttl_next;
    ntta_pkg::gone_t             gone_list[$];
    ntta_pkg::gone_t             g;
    int                          slot;
    int                          keep;
    id   = d[ntta_pkg::IN_ID_LSB +: ntta_pkg::ID_W];
    ip   = d[ntta_pkg::IN_IP_LSB +: ntta_pkg::IP_W];
    cost = d[ntta_pkg::IN_COST_LSB +: ntta_pkg::COST_W];
    len  = d[ntta_pkg::IN_LEN_LSB +: ntta_pkg::LEN_W];
    if (hello) begin
      if (len != ntta_pkg::HELLO_LEN) begin
        push_report(ntta_pkg::ST_BAD_LEN, id, '0, 1'b1);
        return;
      end
      slot = -1;
      for (int i = 0; i < nbr_count; i++)
        if (slot < 0 && nbr_table[i].id == id) slot = i;
      if (slot >= 0) begin
        // refresh keeps the stored address
        nbr_table[slot].cost = cost;
        nbr_table[slot].ttl  = cur_max_ttl;
        push_report(ntta_pkg::ST_REFRESHED, id, cost, 1'b1);
      end else if (nbr_count >= DEPTH) begin
        push_report(ntta_pkg::ST_FULL, id, '0, 1'b1);
      end else begin
        nbr_table[nbr_count].id   = id;
        nbr_table[nbr_count].cost = cost;
        nbr_table[nbr_count].ip   = ip;
        nbr_table[nbr_count].ttl  = cur_max_ttl;
        nbr_count++;
        push_report(ntta_pkg::ST_ADDED, id, cost, 1'b1);
      end
    end else begin
      // age every entry, compact survivors in order
      keep = 0;
      for (int i = 0; i < nbr_count; i++) begin
        ttl_next = nbr_table[i].ttl - 8'd1;
        if (ttl_next == '0) begin
          g.id   = nbr_table[i].id;
          g.cost = nbr_table[i].cost;
          gone_list = {gone_list, g};
        end else begin
          nbr_table[keep]     = nbr_table[i];
          nbr_table[keep].ttl = ttl_next;
          keep++;
        end
      end
      nbr_count = keep;
      foreach (gone_list[k])
        push_report(ntta_pkg::ST_EXPIRED, gone_list[k].id, gone_list[k].cost, 1'b0);
      push_report(ntta_pkg::ST_TICK_DONE, '0, '0, 1'b1);
    end
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // input driver, one transfer per pending item
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (msg_backlog.size() != 0) begin
        next_msg = msg_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_msg.hello;
        in_tdata  <= next_msg.data;
        in_gap    = next_gap(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(3) == 0) out_stall = next_gap(out_calm);
    end
  end

  // monitor: check results, then predict from accepted inputs and writes
  always @(posedge clk) begin
    table_report_t     want;
    ntta_pkg::status_t got_status;
    if (rst_n) begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got_status = ntta_pkg::status_t'(out_tdata[ntta_pkg::STATUS_W-1:0]);
        if (table_reports.size() == 0) begin
          report("result transfer with none pending, status", '0, 64'(got_status));
        end else begin
          want = table_reports.pop_front();
          if (got_status !== want.status)
            report("status", 64'(want.status), 64'(got_status));
          if (out_tdata[ntta_pkg::OUT_ID_LSB +: ntta_pkg::ID_W] !== want.id)
            report("neighbor_id", 64'(want.id),
                   64'(out_tdata[ntta_pkg::OUT_ID_LSB +: ntta_pkg::ID_W]));
          if (out_tdata[ntta_pkg::OUT_COST_LSB +: ntta_pkg::COST_W] !== want.cost)
            report("neighbor_cost", 64'(want.cost),
                   64'(out_tdata[ntta_pkg::OUT_COST_LSB +: ntta_pkg::COST_W]));
          if (out_tdata[ntta_pkg::OUT_CNT_LSB +: ntta_pkg::COUNT_W] !== want.count)
            report("neighbor_count", 64'(want.count),
                   64'(out_tdata[ntta_pkg::OUT_CNT_LSB +: ntta_pkg::COUNT_W]));
          if (out_tlast !== want.last) report("tlast", 64'(want.last), 64'(out_tlast));
        end
      end
      if (cfg_valid && cfg_ready) cur_max_ttl = cfg_data;
      if (in_tvalid && in_tready) update_neighbor_table(in_tuser, in_tdata);
    end else begin
      in_took <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // hold the sender until all results are back and the block is idle;
  // look just after the falling edge, once the driver has settled
  task automatic wait_drained();
    while (msg_backlog.size() != 0 || in_tvalid || table_reports.size() != 0) begin
      @(negedge clk);
      #1;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_max_ttl(logic [ntta_pkg::TTL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random mix: mostly pool hellos, some ticks, bad lengths and fresh IDs
  task automatic add_traffic(int n, int fresh_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 12)
        queue_msg(tick_msg());
      else if (r < 20)
        queue_msg(hello_msg(id_pool[$urandom_range(POOL_SIZE-1)], $urandom(),
                            rand_cost(), rand_len()));
      else if (r < 20 + fresh_pct)
        queue_msg(hello_msg(rand_id(), $urandom(), rand_cost(), ntta_pkg::HELLO_LEN));
      else
        queue_msg(hello_msg(id_pool[$urandom_range(POOL_SIZE-1)], $urandom(),
                            rand_cost(), ntta_pkg::HELLO_LEN));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    out_tready     = 1'b0;
    in_took        = 1'b0;
    in_gap         = 0;
    in_calm        = 0;
    out_stall      = 0;
    out_calm       = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    nbr_count      = 0;
    cur_max_ttl    = ntta_pkg::MAX_TTL_RST;
    foreach (id_pool[i]) id_pool[i] = rand_id();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, length errors, field extremes, refresh, aging at reset ttl
    queue_msg(tick_msg());
    queue_msg(hello_msg('1, '1, '1, '0));
    queue_msg(hello_msg(id_pool[0], '0, '0, '1));
    queue_msg(hello_msg(id_pool[1], 32'h0a000001, 16'h0101, 11'd1));
    queue_msg(hello_msg(id_pool[2], 32'h0a000002, 16'h0202, 11'd3));
    queue_msg(hello_msg('0, '0, '0, ntta_pkg::HELLO_LEN));
    queue_msg(hello_msg('1, '1, '1, ntta_pkg::HELLO_LEN));
    queue_msg(hello_msg('0, 32'hc0a80001, 16'h1234, ntta_pkg::HELLO_LEN));
    queue_msg(tick_msg());
    queue_msg(tick_msg());
    queue_msg(hello_msg('1, '0, 16'h0042, ntta_pkg::HELLO_LEN));
    queue_msg(tick_msg());
    queue_msg(tick_msg());
    queue_msg(tick_msg());
    wait_drained();

    // shortest ttl: entries die on the very next tick
    write_max_ttl(8'd1);
    queue_msg(hello_msg(id_pool[0], 32'h01020304, 16'h0007, ntta_pkg::HELLO_LEN));
    queue_msg(hello_msg(id_pool[1], 32'h05060708, 16'hfffe, ntta_pkg::HELLO_LEN));
    queue_msg(tick_msg());
    queue_msg(hello_msg(id_pool[2], 32'h090a0b0c, 16'h8000, ntta_pkg::HELLO_LEN));
    queue_msg(tick_msg());
    wait_drained();

    // longest ttl: table fills and unknown senders are dropped
    write_max_ttl(8'd255);
    add_traffic(60, 0);
    wait_drained();

    // refresh the whole pool at ttl 1, then one tick empties a full table
    write_max_ttl(8'd1);
    foreach (id_pool[i])
      queue_msg(hello_msg(id_pool[i], $urandom(), rand_cost(), ntta_pkg::HELLO_LEN));
    queue_msg(tick_msg());
    add_traffic(35, 0);
    wait_drained();

    // moderate ttl with fresh senders mixed in
    write_max_ttl(ntta_pkg::TTL_W'($urandom_range(20, 2)));
    add_traffic(30, 6);
    wait_drained();

    repeat (END_CYCLES) @(negedge clk);
    if (table_reports.size() != 0)
      report("results never seen", '0, 64'(table_reports.size()));
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ntta_pkg.sv
sv/ntta_ctrl.sv
sv/ntta_dp.sv
sv/neighbor_table_ttl_aging_top.sv
bench/neighbor_table_ttl_aging_top_tb.sv
